// File: hdl/md5hs_pkg.sv
// ----------------------------------------------------------------------------
// md5hs_pkg
// Shared types, constants and round tables for the MD5 stream hashing core.
// ----------------------------------------------------------------------------
package md5hs_pkg;

    // Block geometry: sixteen 32-bit message words per 512-bit block
    localparam int BLK_WORDS = 16;
    localparam int WORD_AW   = 4;

    // Chaining word initial values
    localparam logic [31:0] INIT_A = 32'h67452301;
    localparam logic [31:0] INIT_B = 32'hefcdab89;
    localparam logic [31:0] INIT_C = 32'h98badcfe;
    localparam logic [31:0] INIT_D = 32'h10325476;

    // Padding marker byte
    localparam logic [7:0] PAD_BYTE = 8'h80;

    // Word slots of the 64-bit length field
    localparam logic [WORD_AW-1:0] LEN_LO_WORD = 4'd14;
    localparam logic [WORD_AW-1:0] LEN_HI_WORD = 4'd15;

    // Per-round additive constants
    localparam logic [31:0] SINE_TAB [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // Input transaction payload
    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       end_of_message;
    } in_item_t;

    // Output transaction payload
    typedef struct packed {
        logic [31:0] digest_word;
        logic [1:0]  word_index;
        logic        last_word;
    } out_item_t;

    // Sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD0,
        ST_LOAD1,
        ST_ROUND,
        ST_ADD,
        ST_PAD_FIRST,
        ST_PAD_ZERO,
        ST_LEN_HI,
        ST_OUT
    } state_t;

    // Message word used by a given round
    function automatic logic [WORD_AW-1:0] msg_index(input logic [5:0] rnd);
        logic [WORD_AW-1:0] r4;
        logic [WORD_AW-1:0] idx;
        r4 = rnd[3:0];
        case (rnd[5:4])
            2'd0:    idx = r4;
            2'd1:    idx = WORD_AW'(r4 * 4'd5 + 4'd1);
            2'd2:    idx = WORD_AW'(r4 * 4'd3 + 4'd5);
            2'd3:    idx = WORD_AW'(r4 * 4'd7);
            default: idx = r4;
        endcase
        return idx;
    endfunction

    // Left-rotate amount of a given round
    function automatic logic [4:0] rot_amount(input logic [5:0] rnd);
        logic [4:0] amt;
        case ({rnd[5:4], rnd[1:0]})
            4'h0: amt = 5'd7;
            4'h1: amt = 5'd12;
            4'h2: amt = 5'd17;
            4'h3: amt = 5'd22;
            4'h4: amt = 5'd5;
            4'h5: amt = 5'd9;
            4'h6: amt = 5'd14;
            4'h7: amt = 5'd20;
            4'h8: amt = 5'd4;
            4'h9: amt = 5'd11;
            4'ha: amt = 5'd16;
            4'hb: amt = 5'd23;
            4'hc: amt = 5'd6;
            4'hd: amt = 5'd10;
            4'he: amt = 5'd15;
            4'hf: amt = 5'd21;
            default: amt = 5'd7;
        endcase
        return amt;
    endfunction

endpackage

// File: hdl/md5hs_ram.sv
// ----------------------------------------------------------------------------
// md5hs_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module md5hs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/md5hs_round.sv
// ----------------------------------------------------------------------------
// md5hs_round
// One MD5 compression round: round function, add, rotate and add.
// The message word, constant and old a arrive pre-summed in pre_sum.
// ----------------------------------------------------------------------------
module md5hs_round (
    input  logic [5:0]  rnd,
    input  logic [31:0] b,
    input  logic [31:0] c,
    input  logic [31:0] d,
    input  logic [31:0] pre_sum,
    output logic [31:0] b_new
);

    logic [31:0] f;
    logic [31:0] sum;
    logic [63:0] rot_wide;
    logic [4:0]  amt;

    // Select the round function by quarter
    always_comb
    begin
        case (rnd[5:4])
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            2'd3:    f = c ^ (b | ~d);
            default: f = b ^ c ^ d;
        endcase
    end

    // Add, rotate left, add b
    assign amt      = md5hs_pkg::rot_amount(rnd);
    assign sum      = f + pre_sum;
    assign rot_wide = {sum, sum} << amt;
    assign b_new    = b + rot_wide[63:32];

endmodule

// File: hdl/md5_hash_stream_core.sv
// ----------------------------------------------------------------------------
// md5_hash_stream_core
// MD5 over a byte stream: gathers bytes into 512-bit blocks, compresses them
// with one shared round unit, pads at end of message and returns the digest.
// ----------------------------------------------------------------------------
// While idle the core takes each byte transaction as offered, unless it fills a
// 64-byte block: then the core runs the compression and is not ready during
// the message word prefetch, the 64 rounds through the single round unit and
// the chaining add. Closing a message writes the padding and length one word
// per cycle (with a further block of zeros and length when the marker leaves
// no room for the length), runs one or two compressions (two when fewer than
// nine bytes of the last block are free), then offers the four digest words as
// four output transactions, word 0 first. The input side is not ready from the
// close until the last digest word is taken, and the chaining words are
// reloaded for the next message.
module md5_hash_stream_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  md5hs_pkg::in_item_t  in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output md5hs_pkg::out_item_t out_data
);

    md5hs_pkg::state_t state_reg, state_next;

    logic [5:0]  round_reg, round_next;
    logic [3:0]  word_idx_reg, word_idx_next;
    logic [1:0]  out_idx_reg, out_idx_next;
    logic        extra_reg, extra_next;
    logic        final_reg, final_next;
    logic        close_pend_reg, close_pend_next;
    logic [63:0] bit_cnt_reg, bit_cnt_next;
    logic [23:0] asm_reg, asm_next;
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] wa_reg, wa_next;
    logic [31:0] wb_reg, wb_next;
    logic [31:0] wc_reg, wc_next;
    logic [31:0] wd_reg, wd_next;
    logic [31:0] pre_reg, pre_next;

    logic        ram_we;
    logic [3:0]  ram_waddr;
    logic [31:0] ram_wdata;
    logic [3:0]  ram_raddr;
    logic [31:0] ram_rdata;

    logic [31:0] b_new;
    logic [5:0]  pos;
    logic [1:0]  lane;
    logic        in_xfer;
    logic        out_xfer;

    assign pos      = bit_cnt_reg[8:3];
    assign lane     = bit_cnt_reg[4:3];
    assign in_ready = (state_reg == md5hs_pkg::ST_IDLE);
    assign out_valid = (state_reg == md5hs_pkg::ST_OUT);
    assign in_xfer  = in_valid & in_ready;
    assign out_xfer = out_valid & out_ready;

    // Present the current digest word
    assign out_data.digest_word = chain_reg[out_idx_reg];
    assign out_data.word_index  = out_idx_reg;
    assign out_data.last_word   = (out_idx_reg == 2'd3);

    // Message block storage, one 32-bit word per entry
    md5hs_ram #(
        .WIDTH (32),
        .DEPTH (md5hs_pkg::BLK_WORDS)
    ) u_blk_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Shared round unit
    md5hs_round u_round (
        .rnd     (round_reg),
        .b       (wb_reg),
        .c       (wc_reg),
        .d       (wd_reg),
        .pre_sum (pre_reg),
        .b_new   (b_new)
    );

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= md5hs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Control and chaining registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            round_reg      <= '0;
            word_idx_reg   <= '0;
            out_idx_reg    <= '0;
            extra_reg      <= 1'b0;
            final_reg      <= 1'b0;
            close_pend_reg <= 1'b0;
            bit_cnt_reg    <= '0;
            chain_reg[0]   <= md5hs_pkg::INIT_A;
            chain_reg[1]   <= md5hs_pkg::INIT_B;
            chain_reg[2]   <= md5hs_pkg::INIT_C;
            chain_reg[3]   <= md5hs_pkg::INIT_D;
        end
        else
        begin
            round_reg      <= round_next;
            word_idx_reg   <= word_idx_next;
            out_idx_reg    <= out_idx_next;
            extra_reg      <= extra_next;
            final_reg      <= final_next;
            close_pend_reg <= close_pend_next;
            bit_cnt_reg    <= bit_cnt_next;
            chain_reg      <= chain_next;
        end
    end

    // Working registers, no reset needed
    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
        wa_reg  <= wa_next;
        wb_reg  <= wb_next;
        wc_reg  <= wc_next;
        wd_reg  <= wd_next;
        pre_reg <= pre_next;
    end

    // Sequencer: next state, datapath control and RAM access
    always_comb
    begin
        state_next      = state_reg;
        round_next      = round_reg;
        word_idx_next   = word_idx_reg;
        out_idx_next    = out_idx_reg;
        extra_next      = extra_reg;
        final_next      = final_reg;
        close_pend_next = close_pend_reg;
        bit_cnt_next    = bit_cnt_reg;
        asm_next        = asm_reg;
        chain_next      = chain_reg;
        wa_next         = wa_reg;
        wb_next         = wb_reg;
        wc_next         = wc_reg;
        wd_next         = wd_reg;
        pre_next        = pre_reg;
        ram_we          = 1'b0;
        ram_waddr       = word_idx_reg;
        ram_wdata       = '0;
        ram_raddr       = md5hs_pkg::msg_index(6'd0);

        case (state_reg)
            md5hs_pkg::ST_IDLE:
            begin
                if (in_xfer)
                begin
                    if (in_data.byte_valid)
                    begin
                        // Gather the byte; store the word when its last lane fills
                        case (lane)
                            2'd0:    asm_next[7:0]   = in_data.data_byte;
                            2'd1:    asm_next[15:8]  = in_data.data_byte;
                            2'd2:    asm_next[23:16] = in_data.data_byte;
                            default:
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = pos[5:2];
                                ram_wdata = {in_data.data_byte, asm_reg};
                            end
                        endcase
                        bit_cnt_next    = bit_cnt_reg + 64'd8;
                        close_pend_next = in_data.end_of_message;
                        if (pos == 6'd63)
                        begin
                            state_next = md5hs_pkg::ST_LOAD0;
                        end
                        else if (in_data.end_of_message)
                        begin
                            state_next = md5hs_pkg::ST_PAD_FIRST;
                        end
                    end
                    else if (in_data.end_of_message)
                    begin
                        close_pend_next = 1'b1;
                        state_next      = md5hs_pkg::ST_PAD_FIRST;
                    end
                end
            end

            md5hs_pkg::ST_LOAD0:
            begin
                // Fetch the first round's message word
                ram_raddr  = md5hs_pkg::msg_index(6'd0);
                round_next = '0;
                state_next = md5hs_pkg::ST_LOAD1;
            end

            md5hs_pkg::ST_LOAD1:
            begin
                // Seed the working words and the first pre-sum
                ram_raddr  = md5hs_pkg::msg_index(6'd1);
                wa_next    = chain_reg[0];
                wb_next    = chain_reg[1];
                wc_next    = chain_reg[2];
                wd_next    = chain_reg[3];
                pre_next   = chain_reg[0] + md5hs_pkg::SINE_TAB[0] + ram_rdata;
                state_next = md5hs_pkg::ST_ROUND;
            end

            md5hs_pkg::ST_ROUND:
            begin
                // One round; the next round's pre-sum uses the current d
                ram_raddr  = md5hs_pkg::msg_index(6'(round_reg + 6'd2));
                wa_next    = wd_reg;
                wb_next    = b_new;
                wc_next    = wb_reg;
                wd_next    = wc_reg;
                pre_next   = wd_reg + md5hs_pkg::SINE_TAB[6'(round_reg + 6'd1)] + ram_rdata;
                round_next = 6'(round_reg + 6'd1);
                if (round_reg == 6'd63)
                begin
                    state_next = md5hs_pkg::ST_ADD;
                end
            end

            md5hs_pkg::ST_ADD:
            begin
                // Fold the working words into the chain, then pick what follows
                chain_next[0] = chain_reg[0] + wa_reg;
                chain_next[1] = chain_reg[1] + wb_reg;
                chain_next[2] = chain_reg[2] + wc_reg;
                chain_next[3] = chain_reg[3] + wd_reg;
                if (final_reg)
                begin
                    final_next   = 1'b0;
                    out_idx_next = '0;
                    state_next   = md5hs_pkg::ST_OUT;
                end
                else if (extra_reg)
                begin
                    extra_next    = 1'b0;
                    word_idx_next = '0;
                    state_next    = md5hs_pkg::ST_PAD_ZERO;
                end
                else if (close_pend_reg)
                begin
                    state_next = md5hs_pkg::ST_PAD_FIRST;
                end
                else
                begin
                    state_next = md5hs_pkg::ST_IDLE;
                end
            end

            md5hs_pkg::ST_PAD_FIRST:
            begin
                // Write the word that holds the 0x80 marker, zeros above it
                ram_we    = 1'b1;
                ram_waddr = pos[5:2];
                case (lane)
                    2'd0:    ram_wdata = {24'd0, md5hs_pkg::PAD_BYTE};
                    2'd1:    ram_wdata = {16'd0, md5hs_pkg::PAD_BYTE, asm_reg[7:0]};
                    2'd2:    ram_wdata = {8'd0, md5hs_pkg::PAD_BYTE, asm_reg[15:0]};
                    default: ram_wdata = {md5hs_pkg::PAD_BYTE, asm_reg};
                endcase
                close_pend_next = 1'b0;
                word_idx_next   = 4'(pos[5:2] + 4'd1);
                if (pos[5:2] >= md5hs_pkg::LEN_LO_WORD)
                begin
                    // No room for the length: close this block first
                    extra_next = 1'b1;
                    if (pos[5:2] == md5hs_pkg::LEN_HI_WORD)
                    begin
                        state_next = md5hs_pkg::ST_LOAD0;
                    end
                    else
                    begin
                        state_next = md5hs_pkg::ST_PAD_ZERO;
                    end
                end
                else
                begin
                    state_next = md5hs_pkg::ST_PAD_ZERO;
                end
            end

            md5hs_pkg::ST_PAD_ZERO:
            begin
                // Fill zero words; in the final block stop at the length slot
                ram_we    = 1'b1;
                ram_waddr = word_idx_reg;
                if (extra_reg)
                begin
                    ram_wdata     = '0;
                    word_idx_next = 4'(word_idx_reg + 4'd1);
                    if (word_idx_reg == md5hs_pkg::LEN_HI_WORD)
                    begin
                        state_next = md5hs_pkg::ST_LOAD0;
                    end
                end
                else if (word_idx_reg == md5hs_pkg::LEN_LO_WORD)
                begin
                    ram_wdata  = bit_cnt_reg[31:0];
                    state_next = md5hs_pkg::ST_LEN_HI;
                end
                else
                begin
                    ram_wdata     = '0;
                    word_idx_next = 4'(word_idx_reg + 4'd1);
                end
            end

            md5hs_pkg::ST_LEN_HI:
            begin
                // Upper length word, then the final compression
                ram_we     = 1'b1;
                ram_waddr  = md5hs_pkg::LEN_HI_WORD;
                ram_wdata  = bit_cnt_reg[63:32];
                final_next = 1'b1;
                state_next = md5hs_pkg::ST_LOAD0;
            end

            md5hs_pkg::ST_OUT:
            begin
                // Hand out the digest; reload the chain after the last word
                if (out_xfer)
                begin
                    out_idx_next = 2'(out_idx_reg + 2'd1);
                    if (out_idx_reg == 2'd3)
                    begin
                        chain_next[0] = md5hs_pkg::INIT_A;
                        chain_next[1] = md5hs_pkg::INIT_B;
                        chain_next[2] = md5hs_pkg::INIT_C;
                        chain_next[3] = md5hs_pkg::INIT_D;
                        bit_cnt_next  = '0;
                        state_next    = md5hs_pkg::ST_IDLE;
                    end
                end
            end

            default:
            begin
                state_next = md5hs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// File: hdl/md5hs_checker.sv
// ----------------------------------------------------------------------------
// md5hs_checker
// Port-level checks of the MD5 stream core, bound to the top level.
// ----------------------------------------------------------------------------
module md5hs_checker (
    input logic                 clk,
    input logic                 rst_n,
    input logic                 in_valid,
    input logic                 in_ready,
    input md5hs_pkg::in_item_t  in_data,
    input logic                 out_valid,
    input logic                 out_ready,
    input md5hs_pkg::out_item_t out_data
);

    // Hold a stalled output transaction
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output transaction changed while stalled");

    // Never take input while the digest is being delivered
    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ready && out_valid))
        else $error("input ready during digest delivery");

    // Advance the word index after each delivered non-final word
    a_word_seq: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !out_data.last_word
        |=> out_valid && out_data.word_index == 2'($past(out_data.word_index) + 2'd1))
        else $error("digest words out of order");

    // Drop out of delivery after the final word
    a_last_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && out_data.last_word |=> !out_valid && in_ready)
        else $error("digest delivery did not end after the last word");

    // Mark the final word exactly at index three
    a_last_flag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.last_word == (out_data.word_index == 2'd3)))
        else $error("last_word flag does not match word index");

endmodule

bind md5_hash_stream_core md5hs_checker u_md5hs_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
